@@ rtl/core/tfo_pkg.sv @@
// tfo_pkg: shared types, codes and the 5x7 font for the text framebuffer streamer
// no dependencies; imported by text_framebuffer_oled_streamer_top, its checker and tb
package tfo_pkg;

    typedef enum logic [1:0] {
        OP_PUT_CHAR = 2'd0,
        OP_CLEAR    = 2'd1,
        OP_PULL     = 2'd2
    } op_t;

    localparam logic [7:0] CTRL_CMD      = 8'h00;
    localparam logic [7:0] CTRL_DATA     = 8'h40;
    localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
    localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
    localparam int         CELL_W        = 6;
    localparam int         CMD_LEN       = 7;

    // glyph columns packed with column 0 in the top byte
    localparam logic [39:0] FONT_DIGIT [10] = '{
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E
    };

    localparam logic [39:0] FONT_LETTER [26] = '{
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
        40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
        40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
        40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
        40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
        40'h0708700807, 40'h6151494543
    };

    localparam logic [39:0] FONT_SPACE   = 40'h0000000000;
    localparam logic [39:0] FONT_MINUS   = 40'h0808080808;
    localparam logic [39:0] FONT_PERIOD  = 40'h0060600000;
    localparam logic [39:0] FONT_DIVIDE  = 40'h2010080402;
    localparam logic [39:0] FONT_TWODOT  = 40'h0036360000;
    localparam logic [39:0] FONT_UNKNOWN = 40'h0201510906;

    // one byte of a character cell; column 5 is the blank gap
    function automatic logic [7:0] glyph_col(input logic [7:0] ch, input logic [2:0] col);
        logic [7:0]  up;
        logic [7:0]  ofs;
        logic [39:0] g;
        logic [7:0]  res;
        up = ch;
        if (ch >= "a" && ch <= "z") begin
            up = ch - 8'd32;
        end
        ofs = 8'd0;
        if (up >= "A" && up <= "Z") begin
            ofs = up - "A";
            g   = FONT_LETTER[ofs[4:0]];
        end else if (up >= "0" && up <= "9") begin
            ofs = up - "0";
            g   = FONT_DIGIT[ofs[3:0]];
        end else if (up == " ") begin
            g = FONT_SPACE;
        end else if (up == "-" || up == "_") begin
            g = FONT_MINUS;
        end else if (up == ".") begin
            g = FONT_PERIOD;
        end else if (up == "/") begin
            g = FONT_DIVIDE;
        end else if (up == ":") begin
            g = FONT_TWODOT;
        end else begin
            g = FONT_UNKNOWN;
        end
        case (col)
            3'd0:    res = g[39:32];
            3'd1:    res = g[31:24];
            3'd2:    res = g[23:16];
            3'd3:    res = g[15:8];
            3'd4:    res = g[7:0];
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

@@ rtl/core/tfo_ram.sv @@
// tfo_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
module tfo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/text_framebuffer_oled_streamer_top.sv @@
// text_framebuffer_oled_streamer_top: text framebuffer with glyph writer and flush streamer
// depends on tfo_pkg (codes, font) and tfo_ram (framebuffer storage)
//
// Text engine for a page-organised monochrome panel. The framebuffer is one ram with a
// single write port, so a put_char is an accept followed by six byte writes, a clear
// writes every framebuffer byte in turn, and after reset the block runs a clearing pass
// over the whole framebuffer before s_ready first rises. A pull returning a command or
// control byte goes straight to the emit state; a pull returning a framebuffer byte
// passes through the fetch state first for the registered ram read. The emit state waits
// while the result register holds a result not yet taken by m_ready. One item is in work
// at a time; a finished result sits in the output register while the next item is accepted.
// panel_ready is written through cfg_wr_en/cfg_wr_data and must only change while the block is idle.
module text_framebuffer_oled_streamer_top
    import tfo_pkg::*;
#(
    parameter int PANEL_WIDTH = 128,
    parameter int PANEL_PAGES = 8,
    parameter int CHUNK_BYTES = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [4:0] s_cell_column,
    input  logic [3:0] s_cell_row,
    input  logic [7:0] s_char_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_stream_byte,
    output logic       m_transfer_start,
    output logic       m_frame_end
);

    localparam int FB_SIZE   = PANEL_WIDTH * PANEL_PAGES;
    localparam int AW        = $clog2(FB_SIZE);
    localparam int CELL_COLS = PANEL_WIDTH / CELL_W;
    localparam int CW        = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int BW        = AW + 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WRITE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic            panel_ready_reg, panel_ready_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [7:0]      char_reg, char_next;
    // flush stream position
    logic            in_data_reg, in_data_next;
    logic            need_ctrl_reg, need_ctrl_next;
    logic [2:0]      cmd_idx_reg, cmd_idx_next;
    logic [AW-1:0]   fb_idx_reg, fb_idx_next;
    logic [CW-1:0]   chunk_reg, chunk_next;
    // pending result
    logic [7:0]      pend_byte_reg, pend_byte_next;
    logic            pend_start_reg, pend_start_next;
    logic            pend_last_reg, pend_last_next;
    logic            pend_data_reg, pend_data_next;
    // result register
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      out_byte_reg, out_byte_next;
    logic            out_start_reg, out_start_next;
    logic            out_last_reg, out_last_next;

    logic            ram_we;
    logic [7:0]      ram_wdata;
    logic [7:0]      ram_rdata;
    logic            cell_ok;
    logic [BW-1:0]   cell_base;
    logic [7:0]      cmd_byte;

    tfo_ram #(
        .WIDTH (8),
        .DEPTH (FB_SIZE)
    ) u_fb_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (addr_reg),
        .wr_data (ram_wdata),
        .rd_addr (addr_reg),
        .rd_data (ram_rdata)
    );

    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign ram_wdata = (state_reg == ST_WRITE) ? glyph_col(char_reg, cnt_reg) : 8'h00;

    assign cell_ok   = ({1'b0, s_cell_column} < 6'(CELL_COLS)) &&
                       ({1'b0, s_cell_row} < 5'(PANEL_PAGES));
    assign cell_base = BW'(s_cell_row) * BW'(PANEL_WIDTH) + BW'(s_cell_column) * BW'(CELL_W);

    always_comb begin
        unique case (cmd_idx_reg)
            3'd0:    cmd_byte = CTRL_CMD;
            3'd1:    cmd_byte = CMD_COL_ADDR;
            3'd2:    cmd_byte = 8'h00;
            3'd3:    cmd_byte = 8'(PANEL_WIDTH - 1);
            3'd4:    cmd_byte = CMD_PAGE_ADDR;
            3'd5:    cmd_byte = 8'h00;
            default: cmd_byte = 8'(PANEL_PAGES - 1);
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        panel_ready_next = cfg_wr_en ? cfg_wr_data : panel_ready_reg;
        addr_next        = addr_reg;
        cnt_next         = cnt_reg;
        char_next        = char_reg;
        in_data_next     = in_data_reg;
        need_ctrl_next   = need_ctrl_reg;
        cmd_idx_next     = cmd_idx_reg;
        fb_idx_next      = fb_idx_reg;
        chunk_next       = chunk_reg;
        pend_byte_next   = pend_byte_reg;
        pend_start_next  = pend_start_reg;
        pend_last_next   = pend_last_reg;
        pend_data_next   = pend_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        out_byte_next    = out_byte_reg;
        out_start_next   = out_start_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_op)
                        OP_PUT_CHAR: begin
                            if (panel_ready_reg && cell_ok) begin
                                addr_next  = AW'(cell_base);
                                char_next  = s_char_code;
                                cnt_next   = 3'd0;
                                state_next = ST_WRITE;
                            end
                        end
                        OP_CLEAR: begin
                            addr_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        OP_PULL: begin
                            if (panel_ready_reg) begin
                                pend_start_next = 1'b0;
                                pend_last_next  = 1'b0;
                                pend_data_next  = 1'b0;
                                pend_byte_next  = 8'h00;
                                state_next      = ST_EMIT;
                                if (!in_data_reg) begin
                                    pend_byte_next  = cmd_byte;
                                    pend_start_next = (cmd_idx_reg == 3'd0);
                                    if (cmd_idx_reg == 3'(CMD_LEN - 1)) begin
                                        cmd_idx_next   = 3'd0;
                                        in_data_next   = 1'b1;
                                        need_ctrl_next = 1'b1;
                                    end else begin
                                        cmd_idx_next = cmd_idx_reg + 3'd1;
                                    end
                                end else if (need_ctrl_reg) begin
                                    pend_byte_next  = CTRL_DATA;
                                    pend_start_next = 1'b1;
                                    need_ctrl_next  = 1'b0;
                                    chunk_next      = '0;
                                end else begin
                                    // framebuffer byte: read it first
                                    pend_data_next = 1'b1;
                                    addr_next      = fb_idx_reg;
                                    state_next     = ST_FETCH;
                                    if (fb_idx_reg == AW'(FB_SIZE - 1)) begin
                                        pend_last_next = 1'b1;
                                        fb_idx_next    = '0;
                                        in_data_next   = 1'b0;
                                    end else begin
                                        fb_idx_next = fb_idx_reg + 1'b1;
                                        if (chunk_reg == CW'(CHUNK_BYTES - 1)) begin
                                            need_ctrl_next = 1'b1;
                                        end else begin
                                            chunk_next = chunk_reg + 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR: begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == AW'(FB_SIZE - 1)) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_WRITE: begin
                addr_next = addr_reg + 1'b1;
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == 3'(CELL_W - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_byte_next  = pend_data_reg ? ram_rdata : pend_byte_reg;
                    out_start_next = pend_start_reg;
                    out_last_next  = pend_last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            panel_ready_reg <= 1'b0;
            addr_reg        <= '0;
            cnt_reg         <= 3'd0;
            in_data_reg     <= 1'b0;
            need_ctrl_reg   <= 1'b0;
            cmd_idx_reg     <= 3'd0;
            fb_idx_reg      <= '0;
            chunk_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            panel_ready_reg <= panel_ready_next;
            addr_reg        <= addr_next;
            cnt_reg         <= cnt_next;
            in_data_reg     <= in_data_next;
            need_ctrl_reg   <= need_ctrl_next;
            cmd_idx_reg     <= cmd_idx_next;
            fb_idx_reg      <= fb_idx_next;
            chunk_reg       <= chunk_next;
            m_valid_reg     <= m_valid_next;
        end
        char_reg       <= char_next;
        pend_byte_reg  <= pend_byte_next;
        pend_start_reg <= pend_start_next;
        pend_last_reg  <= pend_last_next;
        pend_data_reg  <= pend_data_next;
        out_byte_reg   <= out_byte_next;
        out_start_reg  <= out_start_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_stream_byte    = out_byte_reg;
    assign m_transfer_start = out_start_reg;
    assign m_frame_end      = out_last_reg;

    // a pull while the panel is down produces nothing
    a_pull_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == OP_PULL && !panel_ready_reg) |=> (state_reg == ST_IDLE))
        else $error("pull with panel not ready started work");

    // the frame end byte is never a control byte
    a_end_not_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_end && m_transfer_start))
        else $error("frame end flagged on a transfer start");

    // the command index is parked at zero during data transfers
    a_cmd_idx_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        in_data_reg |-> (cmd_idx_reg == 3'd0))
        else $error("command index moved during data phase");

    // a cell write never runs past its six columns
    a_write_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> (cnt_reg <= 3'(CELL_W - 1)))
        else $error("cell write overran");

    // no ram write while a read result is pending
    a_no_write_on_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |=> !ram_we)
        else $error("framebuffer written during a fetch");

endmodule

@@ test/text_framebuffer_oled_streamer_checker.sv @@
// text_framebuffer_oled_streamer_checker: predicts the flush stream and checks every result
// depends on tfo_pkg (op codes, control and command bytes, cell width, command length)
`timescale 1ns / 100ps

module text_framebuffer_oled_streamer_checker
    import tfo_pkg::*;
#(
    parameter int PANEL_WIDTH = 128,
    parameter int PANEL_PAGES = 8,
    parameter int CHUNK_BYTES = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [4:0] s_cell_column,
    input  logic [3:0] s_cell_row,
    input  logic [7:0] s_char_code,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_stream_byte,
    input  logic       m_transfer_start,
    input  logic       m_frame_end,
    output int         mismatch_total,
    output int         results_owed
);

    localparam int FB_SIZE    = PANEL_WIDTH * PANEL_PAGES;
    localparam int CELL_COLS  = PANEL_WIDTH / CELL_W;
    localparam int NUM_CHUNKS = (FB_SIZE + CHUNK_BYTES - 1) / CHUNK_BYTES;
    localparam int STREAM_LEN = CMD_LEN + NUM_CHUNKS + FB_SIZE;

    typedef struct packed {
        logic [7:0] data;
        logic       opens;
        logic       last;
    } flush_byte_t;

    logic [7:0]  frame_copy [FB_SIZE];
    int          stream_at;
    logic        panel_on;
    flush_byte_t owed_q [$];
    int          mismatches;
    int          result_no;

    // five glyph columns, column 0 in the top byte
    function automatic logic [39:0] glyph_of(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= "a" && c <= "z") begin
            c = c - 8'd32;
        end
        case (c)
            "0": return 40'h3E5149453E;
            "1": return 40'h00427F4000;
            "2": return 40'h4261514946;
            "3": return 40'h2141454B31;
            "4": return 40'h1814127F10;
            "5": return 40'h2745454539;
            "6": return 40'h3C4A494930;
            "7": return 40'h0171090503;
            "8": return 40'h3649494936;
            "9": return 40'h064949291E;
            "A": return 40'h7E1111117E;
            "B": return 40'h7F49494936;
            "C": return 40'h3E41414122;
            "D": return 40'h7F4141221C;
            "E": return 40'h7F49494941;
            "F": return 40'h7F09090901;
            "G": return 40'h3E4149497A;
            "H": return 40'h7F0808087F;
            "I": return 40'h00417F4100;
            "J": return 40'h2040413F01;
            "K": return 40'h7F08142241;
            "L": return 40'h7F40404040;
            "M": return 40'h7F020C027F;
            "N": return 40'h7F0408107F;
            "O": return 40'h3E4141413E;
            "P": return 40'h7F09090906;
            "Q": return 40'h3E4151215E;
            "R": return 40'h7F09192946;
            "S": return 40'h4649494931;
            "T": return 40'h01017F0101;
            "U": return 40'h3F4040403F;
            "V": return 40'h1F2040201F;
            "W": return 40'h3F4038403F;
            "X": return 40'h6314081463;
            "Y": return 40'h0708700807;
            "Z": return 40'h6151494543;
            " ": return 40'h0000000000;
            "-", "_": return 40'h0808080808;
            ".": return 40'h0060600000;
            "/": return 40'h2010080402;
            ":": return 40'h0036360000;
            default: return 40'h0201510906;
        endcase
    endfunction

    // byte at the current stream position: window command, then chunked pixel data
    function automatic flush_byte_t next_flush_byte();
        flush_byte_t fb;
        int          q;
        int          k;
        int          r;
        int          idx;
        fb = '0;
        if (stream_at < CMD_LEN) begin
            case (stream_at)
                0: begin
                    fb.data  = CTRL_CMD;
                    fb.opens = 1'b1;
                end
                1: fb.data = CMD_COL_ADDR;
                2: fb.data = 8'h00;
                3: fb.data = 8'(PANEL_WIDTH - 1);
                4: fb.data = CMD_PAGE_ADDR;
                5: fb.data = 8'h00;
                default: fb.data = 8'(PANEL_PAGES - 1);
            endcase
        end else begin
            q = stream_at - CMD_LEN;
            k = q / (CHUNK_BYTES + 1);
            r = q % (CHUNK_BYTES + 1);
            if (r == 0) begin
                fb.data  = CTRL_DATA;
                fb.opens = 1'b1;
            end else begin
                idx = k * CHUNK_BYTES + r - 1;
                if (idx < FB_SIZE) begin
                    fb.data = frame_copy[idx];
                end
                fb.last = (idx == FB_SIZE - 1);
            end
        end
        return fb;
    endfunction

    always @(posedge aclk) begin
        flush_byte_t want;
        flush_byte_t got;
        logic [39:0] glyph;
        int          base;
        if (!aresetn) begin
            foreach (frame_copy[i]) frame_copy[i] = 8'h00;
            stream_at  = 0;
            panel_on   = 1'b0;
            owed_q.delete();
            mismatches = 0;
            result_no  = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.data  = m_stream_byte;
                got.opens = m_transfer_start;
                got.last  = m_frame_end;
                result_no++;
                if (owed_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("flush_check: result %0d unexpected, byte %02h start %0b end %0b",
                                 result_no, got.data, got.opens, got.last);
                    end
                end else begin
                    want = owed_q.pop_front();
                    if (got.data !== want.data || got.opens !== want.opens ||
                        got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("flush_check: result %0d expected byte %02h start %0b ",
                                   result_no, want.data, want.opens);
                            $display("end %0b, got byte %02h start %0b end %0b",
                                     want.last, got.data, got.opens, got.last);
                        end
                    end
                end
            end
            if (cfg_wr_en) begin
                panel_on = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                case (s_op)
                    OP_PUT_CHAR: begin
                        if (panel_on && s_cell_column < CELL_COLS && s_cell_row < PANEL_PAGES) begin
                            glyph = glyph_of(s_char_code);
                            base  = s_cell_row * PANEL_WIDTH + s_cell_column * CELL_W;
                            for (int i = 0; i < 5; i++) begin
                                frame_copy[base + i] = glyph[39 - 8 * i -: 8];
                            end
                            frame_copy[base + 5] = 8'h00;
                        end
                    end
                    OP_CLEAR: begin
                        foreach (frame_copy[i]) frame_copy[i] = 8'h00;
                    end
                    OP_PULL: begin
                        // with the panel down a pull neither answers nor moves the stream
                        if (panel_on) begin
                            owed_q.push_back(next_flush_byte());
                            stream_at = (stream_at + 1 >= STREAM_LEN) ? 0 : stream_at + 1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        mismatch_total <= mismatches;
        results_owed   <= owed_q.size();
    end

endmodule

@@ test/tb.sv @@
// tb: stimulus and verdict for text_framebuffer_oled_streamer_top
// depends on tfo_pkg and text_framebuffer_oled_streamer_checker, which predicts and compares
`timescale 1ns / 100ps

module tb;
    import tfo_pkg::*;

    localparam int         PANEL_WIDTH   = 128;
    localparam int         PANEL_PAGES   = 8;
    localparam int         CHUNK_BYTES   = 128;
    localparam int         CELL_COLS     = PANEL_WIDTH / CELL_W;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    // a clear walks the whole store, so that bounds the tail of any item
    localparam int         SETTLE_CYCLES = PANEL_WIDTH * PANEL_PAGES + 50;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         PHASE_COUNT   = 6;
    localparam logic [5:0] PHASE_READY   = 6'b101101;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_op;
    logic [4:0] s_cell_column;
    logic [3:0] s_cell_row;
    logic [7:0] s_char_code;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_stream_byte;
    logic       m_transfer_start;
    logic       m_frame_end;

    int          mismatch_total;
    int          results_owed;
    int          items_sent;
    int          cycles;
    bit          steady;
    int unsigned ready_left;
    int          ready_pick;

    always #10 aclk = ~aclk;

    text_framebuffer_oled_streamer_top #(
        .PANEL_WIDTH(PANEL_WIDTH),
        .PANEL_PAGES(PANEL_PAGES),
        .CHUNK_BYTES(CHUNK_BYTES)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_cell_column   (s_cell_column),
        .s_cell_row      (s_cell_row),
        .s_char_code     (s_char_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_stream_byte   (m_stream_byte),
        .m_transfer_start(m_transfer_start),
        .m_frame_end     (m_frame_end)
    );

    text_framebuffer_oled_streamer_checker #(
        .PANEL_WIDTH(PANEL_WIDTH),
        .PANEL_PAGES(PANEL_PAGES),
        .CHUNK_BYTES(CHUNK_BYTES)
    ) flush_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_cell_column   (s_cell_column),
        .s_cell_row      (s_cell_row),
        .s_char_code     (s_char_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_stream_byte   (m_stream_byte),
        .m_transfer_start(m_transfer_start),
        .m_frame_end     (m_frame_end),
        .mismatch_total  (mismatch_total),
        .results_owed    (results_owed)
    );

    // receiver: mostly short ready spells and short stalls, a few long stalls, and long stretches always ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_left <= 0;
        end else if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 60) begin
                m_ready    <= 1'b1;
                ready_left <= $urandom_range(0, 7);
            end else if (ready_pick < 88) begin
                m_ready    <= 1'b0;
                ready_left <= $urandom_range(0, 3);
            end else if (ready_pick < 95) begin
                m_ready    <= 1'b1;
                ready_left <= $urandom_range(100, 300);
            end else begin
                m_ready    <= 1'b0;
                ready_left <= $urandom_range(20, 60);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 4) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(32, 126));
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [4:0] col,
                             input logic [3:0] row, input logic [7:0] code);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_cell_column <= col;
        s_cell_row    <= row;
        s_char_code   <= code;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // wait on the clock first so an item accepted just now is already counted as owed
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    task automatic write_panel_ready(input logic value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // a string walked one character per transfer along a row
    task automatic send_text();
        int row;
        int col;
        int len;
        row = $urandom_range(0, PANEL_PAGES - 1);
        col = $urandom_range(0, CELL_COLS - 1);
        len = $urandom_range(1, 12);
        for (int i = 0; i < len && col + i <= 31; i++) begin
            send_item(OP_PUT_CHAR, 5'(col + i), 4'(row), text_char());
        end
    endtask

    task automatic send_noise();
        logic [1:0] op;
        op = 2'($urandom_range(0, 3));
        if (op == OP_CLEAR) begin
            op = OP_UNUSED;
        end
        send_item(op, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)));
    endtask

    initial begin
        int quota;
        int target;
        int pick;
        int n;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_valid       = 1'b0;
        s_op          = OP_PUT_CHAR;
        s_cell_column = '0;
        s_cell_row    = '0;
        s_char_code   = '0;
        items_sent    = 0;
        cycles        = 0;
        steady        = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // panel down: text and pulls do nothing, clear still acts
        write_panel_ready(1'b0);
        send_item(OP_PUT_CHAR, 5'd0, 4'd0, "A");
        send_item(OP_PULL, 5'd0, 4'd0, 8'h00);
        send_item(OP_UNUSED, 5'd31, 4'd15, 8'hFF);
        send_item(OP_CLEAR, 5'd0, 4'd0, 8'h00);

        write_panel_ready(1'b1);
        send_item(OP_PUT_CHAR, 5'd0, 4'd0, "a");
        send_item(OP_PUT_CHAR, 5'(CELL_COLS - 1), 4'(PANEL_PAGES - 1), "Z");
        send_item(OP_PUT_CHAR, 5'd1, 4'd0, "_");
        send_item(OP_PUT_CHAR, 5'd2, 4'd0, "-");
        send_item(OP_PUT_CHAR, 5'd3, 4'd0, "0");
        send_item(OP_PUT_CHAR, 5'd4, 4'd0, "9");
        send_item(OP_PUT_CHAR, 5'd5, 4'd0, " ");
        send_item(OP_PUT_CHAR, 5'd6, 4'd0, ".");
        send_item(OP_PUT_CHAR, 5'd7, 4'd0, "/");
        send_item(OP_PUT_CHAR, 5'd8, 4'd0, ":");
        send_item(OP_PUT_CHAR, 5'd9, 4'd0, 8'hFF);
        // cells off the grid
        send_item(OP_PUT_CHAR, 5'(CELL_COLS), 4'd0, "q");
        send_item(OP_PUT_CHAR, 5'd31, 4'd15, "q");
        send_item(OP_PUT_CHAR, 5'd0, 4'(PANEL_PAGES), "q");
        repeat (4) send_item(OP_PULL, 5'd0, 4'd0, 8'h00);
        send_item(OP_CLEAR, 5'd0, 4'd0, 8'h00);
        send_item(OP_PUT_CHAR, 5'd0, 4'd0, "M");
        send_item(OP_PULL, 5'd31, 4'd15, 8'hFF);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_panel_ready(PHASE_READY[p]);
            quota  = PHASE_READY[p] ? 430 : 60;
            target = items_sent + quota;
            while (items_sent < target) begin
                steady = ($urandom_range(0, 4) == 0);
                pick   = $urandom_range(0, 99);
                if (pick < 45) begin
                    n = $urandom_range(1, 40);
                    repeat (n) send_item(OP_PULL, 5'($urandom_range(0, 31)),
                                         4'($urandom_range(0, 15)), text_char());
                end else if (pick < 80) begin
                    send_text();
                end else if (pick < 97) begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_noise();
                end else if (pick < 98) begin
                    send_item(OP_CLEAR, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                              8'($urandom_range(0, 255)));
                end else begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_total == 0 && results_owed == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
